// File: src/idafs_pkg.sv
// Shared types and constants for the identifier allocator with free stack.
// Used by idafs_stack and id_allocator_free_stack_top; no dependencies.
package idafs_pkg;

  localparam int ID_WIDTH   = 16;
  localparam int FREE_DEPTH = 256;
  localparam int PTR_W      = $clog2(FREE_DEPTH);
  localparam int CNT_W      = $clog2(FREE_DEPTH + 1);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_ZERO      = 2'd3;

  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // Commit command from the controller to the free stack.
  typedef struct packed {
    logic push;
    logic pop;
    id_t  wdata;
  } stk_cmd_t;

endpackage

// File: src/idafs_stack.sv
// LIFO free stack: one synchronous memory plus the fill count.
// Depends on idafs_pkg for widths and the commit command type.
module idafs_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  idafs_pkg::stk_cmd_t cmd,
  output idafs_pkg::id_t     rdata,
  output idafs_pkg::cnt_t    count
);

  idafs_pkg::id_t  mem [idafs_pkg::FREE_DEPTH];
  idafs_pkg::id_t  rdata_r;
  idafs_pkg::cnt_t count_r;
  idafs_pkg::cnt_t count_nxt;
  idafs_pkg::cnt_t top_idx;

  // Top-of-stack index; wraps when empty, the read data is unused then.
  assign top_idx = count_r - idafs_pkg::cnt_t'(1);

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + idafs_pkg::cnt_t'(1);
    end else if (cmd.pop) begin
      count_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[top_idx[idafs_pkg::PTR_W-1:0]];
    end
    if (cmd.push) begin
      mem[count_r[idafs_pkg::PTR_W-1:0]] <= cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign rdata = rdata_r;
  assign count = count_r;

endmodule

// File: src/id_allocator_free_stack_top.sv
// Top level of the identifier allocator: command handshake, high-water counter, results.
// Depends on idafs_pkg and idafs_stack.
//
// A request is taken when start is high and busy is low. In the cycle of acceptance the
// top of the free stack memory is read; its registered read data is ready in the next
// cycle, where the pop or push and the counter update commit. The result is registered
// in the commit cycle and appears on the out_ ports for exactly one cycle with out_valid
// high; it must be captured then, since the block cannot be held off. busy is high for
// the one cycle in between, so a new request can be accepted as soon as busy drops, in
// the same cycle as the previous result is shown.
module id_allocator_free_stack_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_op,
  input  logic [15:0]             in_release_id,
  output logic                    out_valid,
  output logic [15:0]             out_granted_id,
  output logic [15:0]             out_high_water,
  output logic [1:0]              out_status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                state_r;
  logic                state_nxt;
  logic                accept;
  logic                op_r;
  idafs_pkg::id_t      id_r;
  idafs_pkg::id_t      issued_max_r;
  idafs_pkg::id_t      issued_max_nxt;
  idafs_pkg::id_t      granted;
  logic [1:0]          status;
  idafs_pkg::stk_cmd_t cmd;
  idafs_pkg::id_t      top_data;
  idafs_pkg::cnt_t     count;
  logic                stack_empty;
  logic                stack_full;
  logic                out_valid_r;
  idafs_pkg::id_t      out_granted_r;
  idafs_pkg::id_t      out_high_water_r;
  logic [1:0]          out_status_r;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  idafs_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (accept),
    .cmd   (cmd),
    .rdata (top_data),
    .count (count)
  );

  assign stack_empty = (count == '0);
  assign stack_full  = (count == idafs_pkg::cnt_t'(idafs_pkg::FREE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Decide the transaction in the commit cycle.
  always_comb begin
    cmd.push       = 1'b0;
    cmd.pop        = 1'b0;
    cmd.wdata      = id_r;
    issued_max_nxt = issued_max_r;
    granted        = '0;
    status         = idafs_pkg::STAT_OK;
    if (state_r == ST_EXEC) begin
      if (op_r == idafs_pkg::OP_ALLOC) begin
        if (!stack_empty) begin
          cmd.pop = 1'b1;
          granted = top_data;
        end else if (issued_max_r == '1) begin
          status = idafs_pkg::STAT_EXHAUSTED;
        end else begin
          issued_max_nxt = issued_max_r + idafs_pkg::id_t'(1);
          granted        = issued_max_nxt;
        end
      end else begin
        if (id_r == '0) begin
          status = idafs_pkg::STAT_ZERO;
        end else if (stack_full) begin
          status = idafs_pkg::STAT_FULL;
        end else begin
          cmd.push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issued_max_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issued_max_r <= issued_max_nxt;
      out_valid_r  <= (state_r == ST_EXEC);
    end
  end

  // Payload registers: hold the request, capture the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      id_r <= in_release_id;
    end
    if (state_r == ST_EXEC) begin
      out_granted_r    <= granted;
      out_high_water_r <= issued_max_nxt;
      out_status_r     <= status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_granted_id = out_granted_r;
  assign out_high_water = out_high_water_r;
  assign out_status     = out_status_r;

`ifndef SYNTH
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

  a_fail_grants_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != idafs_pkg::STAT_OK) |-> (out_granted_id == '0))
    else $error("identifier granted on a refused transaction");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= idafs_pkg::cnt_t'(idafs_pkg::FREE_DEPTH))
    else $error("free stack count beyond depth");
`endif

endmodule

// File: dv/testbench.sv
// Self-checking testbench for id_allocator_free_stack_top: directed and random requests,
// a free-stack fill and drain, all checked against a cycle-free model.
// Depends on idafs_pkg and the RTL under src/.
`timescale 1ns / 1ps

module testbench;

  localparam int RAND_ITEMS  = 800;
  localparam int QUIET_TAIL  = 150;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    idafs_pkg::id_t granted;
    idafs_pkg::id_t high_water;
    logic [1:0]     status;
  } grant_t;

  // Free-stack allocator model plus the queue of results still owed by the block.
  class alloc_scoreboard;
    idafs_pkg::id_t free_ids[idafs_pkg::FREE_DEPTH];
    int unsigned    free_count;
    idafs_pkg::id_t issued_top;
    grant_t         owed_q[$];
    int unsigned    errors;

    function new();
      free_count = 0;
      issued_top = '0;
      errors     = 0;
    endfunction

    function void note_request(logic op, idafs_pkg::id_t rel_id);
      grant_t g;
      g.granted = '0;
      g.status  = idafs_pkg::STAT_OK;
      if (op == idafs_pkg::OP_ALLOC) begin
        if (free_count > 0) begin
          free_count--;
          g.granted = free_ids[free_count];
        end else if (issued_top == '1) begin
          g.status = idafs_pkg::STAT_EXHAUSTED;
        end else begin
          issued_top = issued_top + 1'b1;
          g.granted  = issued_top;
        end
      end else if (rel_id == '0) begin
        g.status = idafs_pkg::STAT_ZERO;
      end else if (free_count >= idafs_pkg::FREE_DEPTH) begin
        g.status = idafs_pkg::STAT_FULL;
      end else begin
        free_ids[free_count] = rel_id;
        free_count++;
      end
      g.high_water = issued_top;
      owed_q.push_back(g);
    endfunction

    task report(string what, int got, int want);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(idafs_pkg::id_t granted, idafs_pkg::id_t high_water,
                      logic [1:0] status);
      grant_t want;
      if (owed_q.size() == 0) begin
        report("result with no request pending", granted, 0);
        return;
      end
      want = owed_q.pop_front();
      if (granted !== want.granted) report("granted_id", granted, want.granted);
      if (high_water !== want.high_water) report("high_water", high_water, want.high_water);
      if (status !== want.status) report("status", status, want.status);
    endtask
  endclass

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  logic           in_op;
  idafs_pkg::id_t in_release_id;
  logic           out_valid;
  idafs_pkg::id_t out_granted_id;
  idafs_pkg::id_t out_high_water;
  logic [1:0]     out_status;

  alloc_scoreboard sb = new();
  idafs_pkg::id_t  recent_grants[$];
  bit              quiet;
  int              stall_cycles;

  id_allocator_free_stack_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_release_id  (in_release_id),
    .out_valid      (out_valid),
    .out_granted_id (out_granted_id),
    .out_high_water (out_high_water),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Results cannot be held off: capture each one at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_granted_id, out_high_water, out_status);
      if (out_status == idafs_pkg::STAT_OK && out_granted_id != '0 &&
          recent_grants.size() < 64)
        recent_grants.push_back(out_granted_id);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("id_allocator_free_stack_top verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Hold the request until the block takes it, then log the transaction.
  task automatic send_request(input logic op, input idafs_pkg::id_t rel_id);
    start         <= 1'b1;
    in_op         <= op;
    in_release_id <= rel_id;
    do @(posedge clk); while (!(start && !busy));
    sb.note_request(op, rel_id);
  endtask

  // Drop start for a random burst; scramble the payload ports meanwhile.
  task automatic maybe_idle();
    int cycles;
    if (quiet || $urandom_range(0, 99) >= 25) return;
    cycles = $urandom_range(1, 12);
    start         <= 1'b0;
    in_op         <= 1'($urandom());
    in_release_id <= idafs_pkg::id_t'($urandom());
    repeat (cycles) @(posedge clk);
  endtask

  function automatic idafs_pkg::id_t pick_release_id();
    int r;
    int k;
    idafs_pkg::id_t id;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 60 && recent_grants.size() > 0) begin
      k  = $urandom_range(0, recent_grants.size() - 1);
      id = recent_grants[k];
      recent_grants.delete(k);
      return id;
    end
    return idafs_pkg::id_t'($urandom());
  endfunction

  initial begin : stimulus
    int seg_left;
    int alloc_pct;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_op         = idafs_pkg::OP_ALLOC;
    in_release_id = '0;
    quiet         = 1'b0;
    seg_left      = 0;
    alloc_pct     = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fresh grants, release of zero, extreme ids, LIFO reuse, duplicates.
    send_request(idafs_pkg::OP_ALLOC, 16'hFFFF);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_RELEASE, '0);
    send_request(idafs_pkg::OP_RELEASE, 16'hFFFF);
    maybe_idle();
    send_request(idafs_pkg::OP_RELEASE, 16'h0001);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_ALLOC, 16'h5555);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_RELEASE, 16'h8000);
    send_request(idafs_pkg::OP_RELEASE, 16'h7FFF);
    maybe_idle();
    send_request(idafs_pkg::OP_RELEASE, 16'h0002);
    send_request(idafs_pkg::OP_RELEASE, 16'h0005);
    send_request(idafs_pkg::OP_RELEASE, 16'h0005);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_ALLOC, 16'hAAAA);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_ALLOC, '0);

    // Fill the free stack, then push past full; zero is refused before fullness.
    while (sb.free_count < idafs_pkg::FREE_DEPTH) begin
      maybe_idle();
      send_request(idafs_pkg::OP_RELEASE, idafs_pkg::id_t'($urandom_range(1, 16'hFFFF)));
    end
    send_request(idafs_pkg::OP_RELEASE, idafs_pkg::id_t'($urandom_range(1, 16'hFFFF)));
    send_request(idafs_pkg::OP_RELEASE, '0);
    send_request(idafs_pkg::OP_RELEASE, 16'hFFFF);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_RELEASE, 16'h1234);
    send_request(idafs_pkg::OP_RELEASE, 16'h4321);

    // Random segments, each with its own alloc/release mix.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       alloc_pct = 15;
          1:       alloc_pct = 50;
          default: alloc_pct = 85;
        endcase
      end
      seg_left--;
      quiet = (n >= RAND_ITEMS - QUIET_TAIL);
      maybe_idle();
      if ($urandom_range(0, 99) < alloc_pct)
        send_request(idafs_pkg::OP_ALLOC, idafs_pkg::id_t'($urandom()));
      else
        send_request(idafs_pkg::OP_RELEASE, pick_release_id());
    end

    // Drain the stack, then take a few fresh grants from the counter.
    while (sb.free_count > 0)
      send_request(idafs_pkg::OP_ALLOC, idafs_pkg::id_t'($urandom()));
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_ALLOC, 16'hFFFF);
    send_request(idafs_pkg::OP_RELEASE, 16'h00FF);
    send_request(idafs_pkg::OP_ALLOC, '0);
    send_request(idafs_pkg::OP_ALLOC, '0);
    start <= 1'b0;

    while (sb.owed_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("id_allocator_free_stack_top verification clean");
    end else begin
      $display("id_allocator_free_stack_top verification failed");
    end
    $finish;
  end

endmodule

// File: id_allocator_free_stack_top.f
src/idafs_pkg.sv
src/idafs_stack.sv
src/id_allocator_free_stack_top.sv
dv/testbench.sv
